/* design/dbfr_pkg.sv */
// shared types and constants for the double buffered frame receiver
`timescale 1ns / 1ps

package dbfr_pkg;

  // default capacity of each frame buffer in bytes
  localparam int DEFAULT_BUF_BYTES = 32;

  // reset value of both header match registers
  localparam logic [7:0] HEADER_RESET = 8'hAA;

  // header, header, function, length and trailing byte around the payload
  localparam int FRAME_OVERHEAD = 5;

  // register indexes on the configuration port
  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  // fixed buffer positions of the frame head
  localparam logic [4:0] IDX_HEADER_FIRST  = 5'd0;
  localparam logic [4:0] IDX_HEADER_SECOND = 5'd1;
  localparam logic [4:0] IDX_FUNCTION      = 5'd2;
  localparam logic [4:0] IDX_LENGTH        = 5'd3;
  localparam logic [4:0] IDX_BODY          = 5'd4;

  // receive sequencer states
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_HEADER_SECOND,
    ST_FUNCTION,
    ST_LENGTH,
    ST_BODY
  } state_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       hit_first;
    logic       hit_second;
    logic       length_ok;
  } entry_t;

  // one result item
  typedef struct packed {
    logic       store_valid;
    logic       store_buffer;
    logic [4:0] store_index;
    logic [7:0] store_data;
    logic       frame_done;
    logic       done_buffer;
    logic       length_error;
  } result_t;

endpackage

/* design/dbfr_front.sv */
// front part: takes received bytes, classifies them and queues them
`timescale 1ns / 1ps

module dbfr_front #(
  parameter int BUF_BYTES = dbfr_pkg::DEFAULT_BUF_BYTES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      rx_byte,
  input  logic [7:0]      header_first,
  input  logic [7:0]      header_second,
  output logic            q_valid,
  output dbfr_pkg::entry_t q_entry,
  input  logic            q_pop
);
  import dbfr_pkg::*;

  localparam int QUEUE_DEPTH = 2;

  entry_t      q_mem [QUEUE_DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  entry_t      entry_in;
  logic [8:0]  length_sum;

  // classify the incoming byte against headers and buffer capacity
  always_comb begin
    length_sum          = {1'b0, rx_byte} + 9'(FRAME_OVERHEAD);
    entry_in.data       = rx_byte;
    entry_in.hit_first  = (rx_byte == header_first);
    entry_in.hit_second = (rx_byte == header_second);
    entry_in.length_ok  = (length_sum <= 9'(BUF_BYTES));
  end

  // queue handshake
  assign in_stall = (count == 2'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_entry  = q_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry_in;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QUEUE_DEPTH))
    else $error("queue count out of range");

  // back side only pops a filled queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != 2'd0)
    else $error("pop from empty queue");

  // a full queue with no pop stays full next cycle
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (count == 2'(QUEUE_DEPTH)) && !q_pop |=> count == 2'(QUEUE_DEPTH))
    else $error("full queue lost an entry");

endmodule

/* design/dbfr_back.sv */
// back part: frame sequencer with ping-pong buffer selection and result register
`timescale 1ns / 1ps

module dbfr_back #(
  parameter int BUF_BYTES = dbfr_pkg::DEFAULT_BUF_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  dbfr_pkg::entry_t  q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output dbfr_pkg::result_t res
);
  import dbfr_pkg::*;

  localparam int POS_W = $clog2(BUF_BYTES);

  state_t            state;
  state_t            state_next;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [7:0]        frame_length;
  logic [7:0]        frame_length_next;
  logic              active_buffer;
  logic              active_buffer_next;
  logic              body_last;
  result_t           res_next;

  // take the next request when the result register is free or being drained
  assign q_pop = q_valid && (!out_valid || !out_stall);

  // last body byte sits at position length + 4
  assign body_last = (9'(pos) == ({1'b0, frame_length} + 9'(FRAME_OVERHEAD - 1)));

  // next state and frame bookkeeping
  always_comb begin
    state_next         = state;
    pos_next           = pos;
    frame_length_next  = frame_length;
    active_buffer_next = active_buffer;
    if (q_pop) begin
      case (state)
        ST_HUNT: begin
          if (q_entry.hit_first) begin
            state_next = ST_HEADER_SECOND;
          end
        end
        ST_HEADER_SECOND: begin
          if (q_entry.hit_second) begin
            state_next = ST_FUNCTION;
          end else begin
            state_next = ST_HUNT;
          end
        end
        ST_FUNCTION: begin
          state_next = ST_LENGTH;
        end
        ST_LENGTH: begin
          if (q_entry.length_ok) begin
            state_next        = ST_BODY;
            frame_length_next = q_entry.data;
            pos_next          = POS_W'(IDX_BODY);
          end else begin
            state_next = ST_HUNT;
          end
        end
        ST_BODY: begin
          if (body_last) begin
            state_next         = ST_HUNT;
            active_buffer_next = ~active_buffer;
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
        default: begin
          state_next = ST_HUNT;
        end
      endcase
    end
  end

  // result for the byte being taken
  always_comb begin
    res_next              = '0;
    res_next.store_buffer = active_buffer;
    case (state)
      ST_HUNT: begin
        if (q_entry.hit_first) begin
          res_next.store_valid = 1'b1;
          res_next.store_index = IDX_HEADER_FIRST;
          res_next.store_data  = q_entry.data;
        end
      end
      ST_HEADER_SECOND: begin
        if (q_entry.hit_second) begin
          res_next.store_valid = 1'b1;
          res_next.store_index = IDX_HEADER_SECOND;
          res_next.store_data  = q_entry.data;
        end
      end
      ST_FUNCTION: begin
        res_next.store_valid = 1'b1;
        res_next.store_index = IDX_FUNCTION;
        res_next.store_data  = q_entry.data;
      end
      ST_LENGTH: begin
        if (q_entry.length_ok) begin
          res_next.store_valid = 1'b1;
          res_next.store_index = IDX_LENGTH;
          res_next.store_data  = q_entry.data;
        end else begin
          res_next.length_error = 1'b1;
        end
      end
      ST_BODY: begin
        res_next.store_valid = 1'b1;
        res_next.store_index = 5'(pos);
        res_next.store_data  = q_entry.data;
        if (body_last) begin
          res_next.frame_done  = 1'b1;
          res_next.done_buffer = active_buffer;
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_HUNT;
      pos           <= '0;
      frame_length  <= 8'd0;
      active_buffer <= 1'b0;
    end else begin
      state         <= state_next;
      pos           <= pos_next;
      frame_length  <= frame_length_next;
      active_buffer <= active_buffer_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

  // a completed frame is always a stored byte
  a_done_stores: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.frame_done |-> res.store_valid && (res.done_buffer == res.store_buffer))
    else $error("frame done without store");

  // a length error never stores
  a_error_no_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.length_error |-> !res.store_valid)
    else $error("length error with store");

  // finishing a frame flips the active buffer
  a_buffer_flip: assert property (@(posedge clk) disable iff (rst)
    q_pop && res_next.frame_done |=> active_buffer != $past(active_buffer))
    else $error("buffer did not switch after frame");

  // body position stays within the frame
  a_body_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_BODY |-> (9'(pos) >= 9'(IDX_BODY)) &&
      (9'(pos) <= {1'b0, frame_length} + 9'(FRAME_OVERHEAD - 1)))
    else $error("body position out of frame");

endmodule

/* design/double_buffered_frame_receiver_top.sv */
// top level of the double buffered frame receiver with its register port
//
//  channel   valid      stall      payload
//  input     in_valid   in_stall   rx_byte
//  output    out_valid  out_stall  store_*, frame_done, done_buffer, length_error
//  config    psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// one byte per cycle sustained while out_stall stays low; an accepted byte passes a queue
// entry, then the result register, before its result shows on the outputs
// every accepted byte yields exactly one result item
// rst is synchronous and active high: hunting state, buffer 0, headers 0xAA
// in_stall rises only when the two-entry queue is full; out_stall backs up into it
`timescale 1ns / 1ps

module double_buffered_frame_receiver_top #(
  parameter int BUF_BYTES = dbfr_pkg::DEFAULT_BUF_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        store_valid,
  output logic        store_buffer,
  output logic [4:0]  store_index,
  output logic [7:0]  store_data,
  output logic        frame_done,
  output logic        done_buffer,
  output logic        length_error,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dbfr_pkg::*;

  logic       reg_write;
  logic       reg_sel;
  logic [7:0] header_first;
  logic [7:0] header_second;
  logic       q_valid;
  logic       q_pop;
  entry_t     q_entry;
  result_t    res;

  // register port decode
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[2];

  // header match registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_RESET;
      header_second <= HEADER_RESET;
    end else if (reg_write) begin
      case (reg_sel)
        REG_HEADER_FIRST:  header_first  <= pwdata[7:0];
        REG_HEADER_SECOND: header_second <= pwdata[7:0];
        default: begin
          header_first <= header_first;
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_HEADER_FIRST:  prdata = {24'd0, header_first};
      REG_HEADER_SECOND: prdata = {24'd0, header_second};
      default:           prdata = 32'd0;
    endcase
  end

  dbfr_front #(
    .BUF_BYTES(BUF_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .header_first (header_first),
    .header_second(header_second),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop)
  );

  dbfr_back #(
    .BUF_BYTES(BUF_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res      (res)
  );

  // result fields to ports
  assign store_valid  = res.store_valid;
  assign store_buffer = res.store_buffer;
  assign store_index  = res.store_index;
  assign store_data   = res.store_data;
  assign frame_done   = res.frame_done;
  assign done_buffer  = res.done_buffer;
  assign length_error = res.length_error;

endmodule

/* verif/double_buffered_frame_receiver_top_tb.sv */
// self-checking testbench for the double buffered frame receiver top level
`timescale 1ns / 1ps

module double_buffered_frame_receiver_top_tb;
  import dbfr_pkg::*;

  localparam int BUF_BYTES = DEFAULT_BUF_BYTES;
  localparam int MAX_LENGTH = BUF_BYTES - FRAME_OVERHEAD;
  localparam int PHASE_REQUESTS = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  // one row of the directed table; pinned rows carry a hand-written result
  typedef struct {
    logic [7:0] rx;
    logic       pinned;
    result_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        store_valid;
  logic        store_buffer;
  logic [4:0]  store_index;
  logic [7:0]  store_data;
  logic        frame_done;
  logic        done_buffer;
  logic        length_error;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // deframer state mirrored by the testbench
  logic [5:0]  rx_pos = 6'd0;
  logic        rx_buf = 1'b0;
  logic [7:0]  rx_len = 8'd0;
  logic [7:0]  hdr_first = HEADER_RESET;
  logic [7:0]  hdr_second = HEADER_RESET;

  result_t     pending_stores[$];
  stim_row_t   directed_rows[24];
  int          mismatch_count = 0;
  int          useful_requests = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_req = 1'b0;
  int          hold_count = 0;
  int          idle_cycles = 0;

  double_buffered_frame_receiver_top #(.BUF_BYTES(BUF_BYTES)) DUT (.*);

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
    mismatch_count++;
  endtask

  // advance the mirrored deframer by one byte and return the store it causes
  function automatic result_t step_deframer(input logic [7:0] b);
    result_t r;
    r = '0;
    r.store_buffer = rx_buf;
    if (rx_pos == 6'(IDX_HEADER_FIRST)) begin
      if (b == hdr_first) begin
        r.store_valid = 1'b1;
        r.store_index = IDX_HEADER_FIRST;
        r.store_data = b;
        rx_pos = 6'(IDX_HEADER_SECOND);
      end
    end else if (rx_pos == 6'(IDX_HEADER_SECOND)) begin
      // a wrong second header drops back to hunting without a second look
      if (b == hdr_second) begin
        r.store_valid = 1'b1;
        r.store_index = IDX_HEADER_SECOND;
        r.store_data = b;
        rx_pos = 6'(IDX_FUNCTION);
      end else begin
        rx_pos = 6'(IDX_HEADER_FIRST);
      end
    end else if (rx_pos == 6'(IDX_FUNCTION)) begin
      r.store_valid = 1'b1;
      r.store_index = IDX_FUNCTION;
      r.store_data = b;
      rx_pos = 6'(IDX_LENGTH);
    end else if (rx_pos == 6'(IDX_LENGTH)) begin
      if (int'(b) + FRAME_OVERHEAD > BUF_BYTES) begin
        r.length_error = 1'b1;
        rx_pos = 6'(IDX_HEADER_FIRST);
      end else begin
        r.store_valid = 1'b1;
        r.store_index = IDX_LENGTH;
        r.store_data = b;
        rx_len = b;
        rx_pos = 6'(IDX_BODY);
      end
    end else begin
      // payload and trailing byte; the last one closes the frame
      r.store_valid = 1'b1;
      r.store_index = rx_pos[4:0];
      r.store_data = b;
      rx_pos = rx_pos + 6'd1;
      if (int'(rx_pos) >= int'(rx_len) + FRAME_OVERHEAD) begin
        r.frame_done = 1'b1;
        r.done_buffer = rx_buf;
        rx_pos = 6'(IDX_HEADER_FIRST);
        rx_buf = ~rx_buf;
      end
    end
    return r;
  endfunction

  // offer one byte request, wait for acceptance, queue the expected store
  task automatic offer_byte(input logic [7:0] value, input logic pinned = 1'b0,
                            input result_t pinned_want = '0);
    result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= value;
    do @(posedge clk); while (in_stall);
    predicted = step_deframer(value);
    if (predicted.store_valid || predicted.length_error) useful_requests++;
    pending_stores.push_back(pinned ? pinned_want : predicted);
  endtask

  // drop valid and wait for every expected store to come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_stores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_read(input logic idx, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_header(input logic idx, input logic [7:0] want);
    logic [31:0] data;
    apb_read(idx, data);
    if (data[7:0] !== want) report_mismatch("header register readback", want, data[7:0]);
  endtask

  // write one header register, mirror it and read it back
  task automatic write_header(input logic idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_HEADER_FIRST) hdr_first = value;
    else hdr_second = value;
    check_header(idx, value);
  endtask

  // receiver side: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      hold_count = hold_count + 1;
      if (hold_count >= HOLD_CYCLES) begin
        hold_count = 0;
        hold_req = 1'b0;
      end
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare accepted stores and watch for a stuck block
  always @(posedge clk) begin : check_stores
    result_t want;
    result_t got;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
      if (out_valid && !out_stall) begin
        got = '{store_valid, store_buffer, store_index, store_data,
                frame_done, done_buffer, length_error};
        if (pending_stores.size() == 0) begin
          report_mismatch("store with nothing pending", 0, got);
        end else begin
          want = pending_stores.pop_front();
          if (got.store_valid !== want.store_valid)
            report_mismatch("store_valid", want.store_valid, got.store_valid);
          if (got.store_buffer !== want.store_buffer)
            report_mismatch("store_buffer", want.store_buffer, got.store_buffer);
          if (got.store_index !== want.store_index)
            report_mismatch("store_index", want.store_index, got.store_index);
          if (got.store_data !== want.store_data)
            report_mismatch("store_data", want.store_data, got.store_data);
          if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", want.frame_done, got.frame_done);
          if (got.done_buffer !== want.done_buffer)
            report_mismatch("done_buffer", want.done_buffer, got.done_buffer);
          if (got.length_error !== want.length_error)
            report_mismatch("length_error", want.length_error, got.length_error);
        end
      end
    end
  end

  initial begin
    int         kind;
    int         len;
    logic [7:0] wrong;

    // directed frames with reset headers: empty frame, ignored bytes,
    // wrong second header, lengths too large, then a short frame
    directed_rows[0]  = '{8'hAA, 1'b1, '{1'b1, 1'b0, IDX_HEADER_FIRST, 8'hAA, 1'b0, 1'b0, 1'b0}};
    directed_rows[1]  = '{8'hAA, 1'b1, '{1'b1, 1'b0, IDX_HEADER_SECOND, 8'hAA, 1'b0, 1'b0, 1'b0}};
    directed_rows[2]  = '{8'h00, 1'b1, '{1'b1, 1'b0, IDX_FUNCTION, 8'h00, 1'b0, 1'b0, 1'b0}};
    directed_rows[3]  = '{8'h00, 1'b1, '{1'b1, 1'b0, IDX_LENGTH, 8'h00, 1'b0, 1'b0, 1'b0}};
    directed_rows[4]  = '{8'hFF, 1'b1, '{1'b1, 1'b0, IDX_BODY, 8'hFF, 1'b1, 1'b0, 1'b0}};
    directed_rows[5]  = '{8'h00, 1'b1, '{1'b0, 1'b1, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0}};
    directed_rows[6]  = '{8'hFF, 1'b1, '{1'b0, 1'b1, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0}};
    directed_rows[7]  = '{8'hAA, 1'b1, '{1'b1, 1'b1, IDX_HEADER_FIRST, 8'hAA, 1'b0, 1'b0, 1'b0}};
    directed_rows[8]  = '{8'h55, 1'b1, '{1'b0, 1'b1, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0}};
    directed_rows[9]  = '{8'hAA, 1'b1, '{1'b1, 1'b1, IDX_HEADER_FIRST, 8'hAA, 1'b0, 1'b0, 1'b0}};
    directed_rows[10] = '{8'hAA, 1'b1, '{1'b1, 1'b1, IDX_HEADER_SECOND, 8'hAA, 1'b0, 1'b0, 1'b0}};
    directed_rows[11] = '{8'hFF, 1'b1, '{1'b1, 1'b1, IDX_FUNCTION, 8'hFF, 1'b0, 1'b0, 1'b0}};
    directed_rows[12] = '{8'h1C, 1'b1, '{1'b0, 1'b1, 5'd0, 8'h00, 1'b0, 1'b0, 1'b1}};
    directed_rows[13] = '{8'hAA, 1'b1, '{1'b1, 1'b1, IDX_HEADER_FIRST, 8'hAA, 1'b0, 1'b0, 1'b0}};
    directed_rows[14] = '{8'hAA, 1'b1, '{1'b1, 1'b1, IDX_HEADER_SECOND, 8'hAA, 1'b0, 1'b0, 1'b0}};
    directed_rows[15] = '{8'h01, 1'b1, '{1'b1, 1'b1, IDX_FUNCTION, 8'h01, 1'b0, 1'b0, 1'b0}};
    directed_rows[16] = '{8'hFF, 1'b1, '{1'b0, 1'b1, 5'd0, 8'h00, 1'b0, 1'b0, 1'b1}};
    directed_rows[17] = '{8'hAA, 1'b0, '0};
    directed_rows[18] = '{8'hAA, 1'b0, '0};
    directed_rows[19] = '{8'h80, 1'b0, '0};
    directed_rows[20] = '{8'h02, 1'b0, '0};
    directed_rows[21] = '{8'hFF, 1'b0, '0};
    directed_rows[22] = '{8'h00, 1'b0, '0};
    directed_rows[23] = '{8'h5A, 1'b0, '0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // headers come out of reset at their default
    check_header(REG_HEADER_FIRST, HEADER_RESET);
    check_header(REG_HEADER_SECOND, HEADER_RESET);

    for (int i = 0; i < $size(directed_rows); i++)
      offer_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].want);
    settle();

    // random phases, each with its own headers and idling mix
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 74;
          stall_pct = 0;
          write_header(REG_HEADER_FIRST, 8'h00);
          write_header(REG_HEADER_SECOND, 8'hFF);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 74;
          write_header(REG_HEADER_FIRST, 8'hFF);
          write_header(REG_HEADER_SECOND, 8'h00);
          // receiver backs off for a long stretch while bytes keep coming
          hold_req = 1'b1;
        end
        default: begin
          idle_pct = 21;
          stall_pct = 21;
          write_header(REG_HEADER_FIRST, 8'($urandom));
          write_header(REG_HEADER_SECOND, 8'($urandom));
        end
      endcase

      useful_requests = 0;
      while (useful_requests < PHASE_REQUESTS) begin
        kind = $urandom_range(99);
        if (kind < 78) begin
          // well-formed head, then either a good frame or an oversized length
          offer_byte(hdr_first);
          offer_byte(hdr_second);
          offer_byte(8'($urandom));
          if (kind < 70) begin
            case ($urandom_range(9))
              0: len = MAX_LENGTH;
              1: len = 0;
              default: len = $urandom_range(MAX_LENGTH / 3);
            endcase
            offer_byte(8'(len));
            repeat (len + 1) offer_byte(8'($urandom));
          end else begin
            offer_byte(8'($urandom_range(255, MAX_LENGTH + 1)));
          end
        end else if (kind < 88) begin
          // broken head, sometimes repeating the first header byte
          if ($urandom_range(1) == 1 && hdr_first != hdr_second) begin
            wrong = hdr_first;
          end else begin
            do wrong = 8'($urandom); while (wrong == hdr_second);
          end
          offer_byte(hdr_first);
          offer_byte(wrong);
        end else begin
          repeat ($urandom_range(4, 1)) offer_byte(8'($urandom));
        end
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
